[hdl/lzss_pkg.sv]
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the LZSS decompressor: controller states,
// token kinds and the fixed byte-level constants of the token format.
// ----------------------------------------------------------------------------
package lzss_pkg;

   // Width of a literal and of one window entry
   localparam int unsigned BYTE_BITS = 8;

   // Value that fills the window after reset and after end of stream
   localparam logic [BYTE_BITS-1:0] SPACE_CHAR = 8'h20;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_COPY  = 3'b100
   } state_type;

   // What the bit parser expects next
   typedef enum logic [1:0] {
      KIND_FLAG  = 2'd0,
      KIND_LIT   = 2'd1,
      KIND_MATCH = 2'd2
   } kind_type;

endpackage

[hdl/lzss_decompressor_core.sv]
// ----------------------------------------------------------------------------
// lzss_decompressor_core
// LZSS decompressor with a ring window of 2^WINDOW_BITS bytes.
// ----------------------------------------------------------------------------
// Usage:
// - req_ channel carries one compressed byte per item, bits parsed MSB first;
//   req_tlast marks the last byte of a stream. rsp_ channel carries one
//   decompressed byte per item; rsp_tlast is set on the final byte produced
//   by a given input item. An input byte that completes no token yields none.
// - A literal token leaves on rsp_ in the cycle after its last input byte is
//   taken, and the next byte can be taken in that same cycle.
// - A match reads the window one byte per cycle through the RAM read port and
//   gives length code + 2 output bytes, one per cycle unless rsp_ stalls, with
//   a forwarding register when a copy reads the entry just written.
// - Reset starts a clearing pass that writes spaces over the whole window
//   (2048 entries at the default size); req_tready stays low during it. The
//   same pass runs after the results of a req_tlast byte.
// - When rsp_tready is low while an item waits, the output register holds it,
//   the copy engine freezes and no new input byte is taken.
// ----------------------------------------------------------------------------
module lzss_decompressor_core #(
   parameter int unsigned WINDOW_BITS = 11,
   parameter int unsigned LENGTH_BITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   // compressed input
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] code_byte
   input  logic       req_tlast,   // end_of_stream
   // decompressed output
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // last_of_run
);

   localparam int unsigned BB         = lzss_pkg::BYTE_BITS;
   localparam int unsigned MATCH_BITS = WINDOW_BITS + LENGTH_BITS;
   localparam int unsigned CNT_W      = $clog2(MATCH_BITS + 1);
   localparam int unsigned LEFT_W     = LENGTH_BITS + 1;
   localparam int unsigned WIN_DEPTH  = 2 ** WINDOW_BITS;
   localparam logic [WINDOW_BITS-1:0] PTR_START =
      WINDOW_BITS'(WIN_DEPTH - (2 ** LENGTH_BITS) - 1);

   // Control state
   lzss_pkg::state_type   state_ff, state_in;
   lzss_pkg::kind_type    kind_ff, kind_in;
   logic [MATCH_BITS-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [WINDOW_BITS-1:0] wp_ff, wp_in;
   logic [WINDOW_BITS-1:0] clr_ff, clr_in;
   logic [LEFT_W-1:0]      left_ff, left_in;
   logic                   eos_ff, eos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   fwd_ff, fwd_in;
   // Payload
   logic [WINDOW_BITS-1:0] rd_addr_ff, rd_addr_in;
   logic [BB-1:0]          fwd_data_ff, fwd_data_in;
   logic [BB-1:0]          rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Parser outputs for the byte on req_tdata
   lzss_pkg::kind_type    p_kind;
   logic [MATCH_BITS-1:0]  p_acc;
   logic [CNT_W-1:0]       p_cnt;
   logic                   tok_lit;
   logic                   tok_match;
   logic [BB-1:0]          tok_byte;
   logic [MATCH_BITS-1:0]  tok_payload;

   // RAM access
   logic                   ram_we;
   logic [WINDOW_BITS-1:0] ram_waddr;
   logic [BB-1:0]          ram_wdata;
   logic                   ram_re;
   logic [BB-1:0]          ram_rdata;

   logic                   req_take;
   logic                   adv;
   logic                   out_load;
   logic [BB-1:0]          copy_byte;
   logic [WINDOW_BITS-1:0] next_rd;

   lzss_ram #(
      .WIDTH (BB),
      .DEPTH (WIN_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_addr_in),
      .rd_data (ram_rdata)
   );

   // Output register may be reloaded when empty or being taken
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == lzss_pkg::ST_IDLE) && adv;
   assign req_take   = req_tvalid && req_tready;
   assign copy_byte  = fwd_ff ? fwd_data_ff : ram_rdata;
   assign next_rd    = rd_addr_ff + WINDOW_BITS'(1);

   // Parse the eight bits of one byte, MSB first; at most one token completes
   always_comb begin
      p_kind      = kind_ff;
      p_acc       = acc_ff;
      p_cnt       = cnt_ff;
      tok_lit     = 1'b0;
      tok_match   = 1'b0;
      tok_byte    = acc_ff[BB-1:0];
      tok_payload = acc_ff;
      for (int i = BB - 1; i >= 0; i--) begin
         case (p_kind) inside
            lzss_pkg::KIND_LIT, lzss_pkg::KIND_MATCH: begin
               p_acc = {p_acc[MATCH_BITS-2:0], req_tdata[i]};
               p_cnt = p_cnt + CNT_W'(1);
               if (p_kind == lzss_pkg::KIND_LIT && p_cnt == CNT_W'(BB)) begin
                  tok_lit  = 1'b1;
                  tok_byte = p_acc[BB-1:0];
                  p_kind   = lzss_pkg::KIND_FLAG;
               end else if (p_kind == lzss_pkg::KIND_MATCH &&
                            p_cnt == CNT_W'(MATCH_BITS)) begin
                  tok_match   = 1'b1;
                  tok_payload = p_acc;
                  p_kind      = lzss_pkg::KIND_FLAG;
               end
            end
            default: begin
               // awaiting flag bit
               p_kind = req_tdata[i] ? lzss_pkg::KIND_LIT : lzss_pkg::KIND_MATCH;
               p_acc  = '0;
               p_cnt  = '0;
            end
         endcase
      end
   end

   // Controller: accept, copy, clear
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      clr_in       = clr_ff;
      left_in      = left_ff;
      eos_in       = eos_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      rd_addr_in   = rd_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      out_load     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = wp_ff;
      ram_wdata    = tok_byte;
      ram_re       = 1'b0;

      unique case (state_ff)
         lzss_pkg::ST_CLEAR: begin
            // sweep spaces over the window
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = lzss_pkg::SPACE_CHAR;
            clr_in    = clr_ff + WINDOW_BITS'(1);
            if (clr_ff == '1) begin
               state_in = lzss_pkg::ST_IDLE;
            end
         end
         lzss_pkg::ST_IDLE: begin
            if (req_take) begin
               kind_in = p_kind;
               acc_in  = p_acc;
               cnt_in  = p_cnt;
               eos_in  = req_tlast;
               if (req_tlast) begin
                  kind_in = lzss_pkg::KIND_FLAG;
                  acc_in  = '0;
                  cnt_in  = '0;
               end
               if (tok_lit) begin
                  // emit literal and record it in the window
                  out_load    = 1'b1;
                  rsp_data_in = tok_byte;
                  rsp_last_in = 1'b1;
                  ram_we      = 1'b1;
                  wp_in       = wp_ff + WINDOW_BITS'(1);
               end
               if (tok_match) begin
                  // issue the first window read
                  ram_re     = 1'b1;
                  rd_addr_in = tok_payload[MATCH_BITS-1:LENGTH_BITS];
                  fwd_in     = 1'b0;
                  left_in    = LEFT_W'(tok_payload[LENGTH_BITS-1:0]) + LEFT_W'(2);
                  state_in   = lzss_pkg::ST_COPY;
               end else if (req_tlast) begin
                  state_in = lzss_pkg::ST_CLEAR;
                  clr_in   = '0;
                  wp_in    = PTR_START;
               end
            end
         end
         lzss_pkg::ST_COPY: begin
            if (adv) begin
               // emit one copied byte, write it back, read the next if any remain
               out_load    = 1'b1;
               rsp_data_in = copy_byte;
               rsp_last_in = (left_ff == LEFT_W'(1));
               ram_we      = 1'b1;
               ram_wdata   = copy_byte;
               wp_in       = wp_ff + WINDOW_BITS'(1);
               if (left_ff != LEFT_W'(1)) begin
                  ram_re      = 1'b1;
                  rd_addr_in  = next_rd;
                  fwd_in      = (next_rd == wp_ff);
                  fwd_data_in = copy_byte;
                  left_in     = left_ff - LEFT_W'(1);
               end else if (eos_ff) begin
                  state_in = lzss_pkg::ST_CLEAR;
                  clr_in   = '0;
                  wp_in    = PTR_START;
               end else begin
                  state_in = lzss_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lzss_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // output valid: set on load, drop when taken
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzss_pkg::ST_CLEAR;
         kind_ff      <= lzss_pkg::KIND_FLAG;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         wp_ff        <= PTR_START;
         clr_ff       <= '0;
         left_ff      <= '0;
         eos_ff       <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         clr_ff       <= clr_in;
         left_ff      <= left_in;
         eos_ff       <= eos_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Never overwrite an output item that is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten while stalled");

   // A copy in progress always has bytes left
   a_copy_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzss_pkg::ST_COPY) |-> (left_ff != '0))
      else $error("copy engine running with zero bytes left");

   // Forwarded read was issued at the entry written just before
   a_fwd_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzss_pkg::ST_COPY && fwd_ff) |->
         (wp_ff == rd_addr_ff + WINDOW_BITS'(1)))
      else $error("forwarding flag set for a non-adjacent read");

   // Clearing pass keeps the write pointer at its start value
   a_clear_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzss_pkg::ST_CLEAR) |-> (wp_ff == PTR_START))
      else $error("write pointer moved during clearing pass");

endmodule

[hdl/lzss_ram.sv]
// ----------------------------------------------------------------------------
// lzss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low; a read of the entry written
// in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module lzss_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[test/lzss_decompressor_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzss_decompressor_core_tb
// Self-checking bench for the LZSS decompressor. Compressed streams are built
// token by token (literals, window copies, truncated tails, raw noise), fed
// through the req_ channel with random gaps, and every rsp_ item is compared
// with the output of a bit-level decoder that keeps its own history window.
// ----------------------------------------------------------------------------
module lzss_decompressor_core_tb;

   localparam int WIN_BITS    = 11;
   localparam int LEN_BITS    = 4;
   localparam int WIN_SIZE    = 1 << WIN_BITS;
   localparam int MATCH_BITS  = WIN_BITS + LEN_BITS;
   localparam int PTR_START   = WIN_SIZE - ((1 << LEN_BITS) + 1);
   localparam int RANDOM_ITEMS = 260;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 5000000;

   typedef struct packed {
      logic [7:0] code;
      logic       eos;
   } code_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] code_byte
   logic       req_tlast;   // end_of_stream
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tlast;   // last_of_run

   // compressed bytes waiting to be sent, decoded bytes waiting to arrive
   code_item_type code_q[$];
   byte_item_type decoded_q[$];

   // decoder shadow state
   logic [7:0]          hist_mem [WIN_SIZE];
   logic [WIN_BITS-1:0] hist_wp;
   logic [15:0]         tok_acc;
   logic [4:0]          tok_cnt;
   lzss_pkg::kind_type  tok_kind;

   // stream builder state
   bit                  gen_bits[$];
   logic [WIN_BITS-1:0] gen_wp;

   int  err_count;
   int  n_items;
   int  n_results;
   int  n_streams;
   int  n_literals;
   int  n_matches;
   int  cycle_count;
   bit  req_fire;
   int  req_gap;
   int  rsp_hold;
   bit  req_calm;
   int  req_calm_left;
   bit  rsp_calm;
   int  rsp_calm_left;

   lzss_decompressor_core #(
      .WINDOW_BITS(WIN_BITS),
      .LENGTH_BITS(LEN_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
   end

   // ------------------------------------------------------------------------
   // Decoder shadow
   // ------------------------------------------------------------------------

   // Fill the window with spaces and restart the parser
   task automatic clear_history();
      for (int i = 0; i < WIN_SIZE; i++) begin
         hist_mem[i] = lzss_pkg::SPACE_CHAR;
      end
      hist_wp  = WIN_BITS'(PTR_START);
      tok_acc  = '0;
      tok_cnt  = '0;
      tok_kind = lzss_pkg::KIND_FLAG;
   endtask

   // Parse one code byte MSB first and queue the bytes it decodes to
   task automatic decode_code_byte(input logic [7:0] code, input logic eos);
      logic [7:0]          run[$];
      logic [7:0]          b;
      logic [WIN_BITS-1:0] pos;
      int                  copy_len;
      byte_item_type       item;
      for (int i = 7; i >= 0; i--) begin
         if (tok_kind == lzss_pkg::KIND_LIT || tok_kind == lzss_pkg::KIND_MATCH) begin
            tok_acc = {tok_acc[14:0], code[i]};
            tok_cnt = tok_cnt + 5'd1;
            if (tok_kind == lzss_pkg::KIND_LIT && tok_cnt == 5'd8) begin
               b = tok_acc[7:0];
               hist_mem[hist_wp] = b;
               hist_wp = hist_wp + 1'b1;
               run.push_back(b);
               tok_kind = lzss_pkg::KIND_FLAG;
            end else if (tok_kind == lzss_pkg::KIND_MATCH &&
                         tok_cnt == 5'(MATCH_BITS)) begin
               pos      = tok_acc[MATCH_BITS-1:LEN_BITS];
               copy_len = int'(tok_acc[LEN_BITS-1:0]) + 2;
               // read before write so an overlapping copy repeats fresh bytes
               for (int k = 0; k < copy_len; k++) begin
                  b = hist_mem[pos];
                  hist_mem[hist_wp] = b;
                  hist_wp = hist_wp + 1'b1;
                  pos = pos + 1'b1;
                  run.push_back(b);
               end
               tok_kind = lzss_pkg::KIND_FLAG;
            end
         end else begin
            tok_kind = code[i] ? lzss_pkg::KIND_LIT : lzss_pkg::KIND_MATCH;
            tok_acc  = '0;
            tok_cnt  = '0;
         end
      end
      foreach (run[j]) begin
         item.data = run[j];
         item.last = (j == run.size() - 1);
         decoded_q.push_back(item);
      end
      if (eos) begin
         clear_history();
      end
   endtask

   // ------------------------------------------------------------------------
   // Stream builder
   // ------------------------------------------------------------------------

   task automatic put_raw(input logic [7:0] code, input logic eos);
      code_item_type item;
      item.code = code;
      item.eos  = eos;
      code_q.push_back(item);
   endtask

   // Append bits MSB first and move every whole byte to the send queue
   task automatic put_bits(input int unsigned value, input int n);
      logic [7:0] code;
      for (int i = n - 1; i >= 0; i--) begin
         gen_bits.push_back(value[i]);
      end
      while (gen_bits.size() >= 8) begin
         for (int i = 7; i >= 0; i--) begin
            code[i] = gen_bits.pop_front();
         end
         put_raw(code, 1'b0);
      end
   endtask

   task automatic put_literal(input logic [7:0] value);
      put_bits(1, 1);
      put_bits(32'(value), 8);
      gen_wp = gen_wp + 1'b1;
      n_literals++;
   endtask

   task automatic put_match(input logic [WIN_BITS-1:0] pos, input logic [LEN_BITS-1:0] code);
      put_bits(0, 1);
      put_bits(32'(pos), WIN_BITS);
      put_bits(32'(code), LEN_BITS);
      gen_wp = gen_wp + WIN_BITS'(code) + WIN_BITS'(2);
      n_matches++;
   endtask

   // Start a copy token and stop short of its end, at a byte boundary
   task automatic put_truncated_match();
      int fill;
      put_bits(0, 1);
      fill = (8 - gen_bits.size() % 8) % 8;
      if (fill > 0) begin
         put_bits($urandom_range(0, (1 << fill) - 1), fill);
      end
      if (fill <= MATCH_BITS - 9 && $urandom_range(0, 1) == 1) begin
         put_bits($urandom_range(0, 255), 8);
      end
   endtask

   // Pad to a byte with random bits and mark the final byte end of stream
   task automatic close_stream();
      int            pad;
      code_item_type item;
      pad = (8 - gen_bits.size() % 8) % 8;
      if (pad > 0) begin
         put_bits($urandom_range(0, (1 << pad) - 1), pad);
      end
      if (code_q.size() == 0 || code_q[$].eos) begin
         put_raw(8'($urandom_range(0, 255)), 1'b0);
      end
      item = code_q.pop_back();
      item.eos = 1'b1;
      code_q.push_back(item);
      gen_wp = WIN_BITS'(PTR_START);
      n_streams++;
   endtask

   // Random well-formed stream, sometimes cut inside a copy token
   task automatic put_random_stream();
      int                  n_tok;
      logic [WIN_BITS-1:0] pos;
      n_tok = $urandom_range(4, 40);
      for (int t = 0; t < n_tok; t++) begin
         if ($urandom_range(0, 1) == 0) begin
            put_literal(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               pos = WIN_BITS'($urandom_range(0, WIN_SIZE - 1));
            end else begin
               pos = gen_wp - WIN_BITS'($urandom_range(1, 40));
            end
            put_match(pos, LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1)));
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         put_truncated_match();
      end
      close_stream();
   endtask

   // Unstructured bytes, the last one ending the stream
   task automatic put_noise_stream();
      int n;
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         put_raw(8'($urandom_range(0, 255)), i == n - 1);
      end
      n_streams++;
   endtask

   // ------------------------------------------------------------------------
   // Idle pattern: short gaps mostly, a few long, with calm stretches
   // ------------------------------------------------------------------------
   task automatic next_gap(inout bit calm, inout int calm_left, output int gap);
      int r;
      if (calm_left == 0) begin
         calm      = ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(20, 80);
      end
      calm_left--;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         gap = 0;
      end else if (r < 94) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(10, 40);
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: present code bytes at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      code_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (code_q.size() > 0) begin
            item = code_q.pop_front();
            req_tdata  <= item.code;
            req_tlast  <= item.eos;
            req_tvalid <= 1'b1;
            next_gap(req_calm, req_calm_left, req_gap);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result side at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         next_gap(rsp_calm, rsp_calm_left, rsp_hold);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check results first, then decode the byte taken at this edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      byte_item_type want;
      req_fire = !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (decoded_q.size() == 0) begin
            err_count++;
            if (err_count <= 50) begin
               $display("%0t: unexpected result byte %02h last %0b", $time,
                        rsp_tdata, rsp_tlast);
            end
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tdata !== want.data) begin
               err_count++;
               if (err_count <= 50) begin
                  $display("%0t: out_byte expected %02h actual %02h", $time,
                           want.data, rsp_tdata);
               end
            end
            if (rsp_tlast !== want.last) begin
               err_count++;
               if (err_count <= 50) begin
                  $display("%0t: last_of_run expected %0b actual %0b", $time,
                           want.last, rsp_tlast);
               end
            end
         end
      end
      if (req_fire) begin
         n_items++;
         decode_code_byte(req_tdata, req_tlast);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
               decoded_q.size());
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      int target;
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      req_fire      = 1'b0;
      req_gap       = 0;
      rsp_hold      = 0;
      req_calm      = 1'b0;
      req_calm_left = 0;
      rsp_calm      = 1'b0;
      rsp_calm_left = 0;
      err_count     = 0;
      n_items       = 0;
      n_results     = 0;
      n_streams     = 0;
      n_literals    = 0;
      n_matches     = 0;
      cycle_count   = 0;
      gen_wp        = WIN_BITS'(PTR_START);
      clear_history();

      // literal extremes, copies at window start and end, wrapping reads,
      // overlapping copies, then an end of stream inside a copy token
      put_literal(8'h00);
      put_literal(8'hFF);
      put_match('0, '0);
      put_match(WIN_BITS'(WIN_SIZE - 1), '1);
      put_match(gen_wp - 1'b1, '1);
      put_match(gen_wp, LEN_BITS'(3));
      put_literal(8'h41);
      put_truncated_match();
      close_stream();
      // raw extremes, then a stream of a single byte
      put_raw(8'h00, 1'b0);
      put_raw(8'hFF, 1'b0);
      put_raw(8'hFF, 1'b0);
      put_raw(8'h00, 1'b1);
      put_raw(8'hFF, 1'b1);
      n_streams += 2;
      // after restart the window must read back spaces around the pointer
      put_match(WIN_BITS'(PTR_START - 5), '1);
      close_stream();

      target = code_q.size() + RANDOM_ITEMS;
      while (code_q.size() < target) begin
         if ($urandom_range(0, 4) == 0) begin
            put_noise_stream();
         end else begin
            put_random_stream();
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // drain
      while (code_q.size() != 0 || req_tvalid || decoded_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_q.size() != 0) begin
         err_count++;
         $display("%0t: %0d results never arrived", $time, decoded_q.size());
      end

      $display("Decoded %0d streams: %0d code bytes with %0d literals and %0d copies",
               n_streams, n_items, n_literals, n_matches);
      $display("Checked %0d output bytes in %0d cycles, %0d errors", n_results,
               cycle_count, err_count);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/lzss_pkg.sv
hdl/lzss_ram.sv
hdl/lzss_decompressor_core.sv
test/lzss_decompressor_core_tb.sv
